@@ hdl/scwsa_pkg.sv @@
// ----------------------------------------------------------------------------
// scwsa_pkg: shared definitions of the sparse convolution scatter block
// Sizes, operation codes, register indexes, sequencer states and the payload
// and control structures used by more than one file.
// ----------------------------------------------------------------------------
`default_nettype none

package scwsa_pkg;

  localparam int MAX_CHANNELS   = 16;
  localparam int MAX_IN_DIM     = 32;
  localparam int MAX_OUT_PIXELS = 1024;
  localparam int MAX_KERNEL     = 8;

  localparam int CH_W        = $clog2(MAX_CHANNELS);
  localparam int DIM_W       = $clog2(MAX_IN_DIM);
  localparam int PIX_W       = $clog2(MAX_OUT_PIXELS);
  localparam int STORE_DEPTH = MAX_CHANNELS * MAX_IN_DIM * MAX_IN_DIM;
  localparam int STORE_AW    = $clog2(STORE_DEPTH);

  // Signed width of an input position: output index times stride plus the
  // tap offset, less the padding.
  localparam int POS_W = 12;

  localparam int REG_AW = 5;

  typedef enum logic [1:0] {
    OP_LOAD  = 2'd0,
    OP_APPLY = 2'd1,
    OP_READ  = 2'd2,
    OP_CLEAR = 2'd3
  } opcode_t;

  typedef enum logic [2:0] {
    REG_INPUT_OFFSET  = 3'd0,
    REG_INPUT_WIDTH   = 3'd1,
    REG_INPUT_HEIGHT  = 3'd2,
    REG_OUTPUT_WIDTH  = 3'd3,
    REG_OUTPUT_HEIGHT = 3'd4,
    REG_CONV_STRIDE   = 3'd5,
    REG_CONV_PAD      = 3'd6,
    REG_CONV_DILATION = 3'd7
  } reg_index_t;

  typedef enum logic [1:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_APPLY,
    ST_DRAIN
  } state_t;

  typedef struct packed {
    logic [1:0]        opcode;
    logic [3:0]        channel;
    logic [4:0]        act_row;
    logic [4:0]        act_col;
    logic signed [7:0] activation;
    logic [2:0]        tap_row;
    logic [2:0]        tap_col;
    logic signed [7:0] weight;
    logic [9:0]        out_index;
  } in_item_t;

  typedef struct packed {
    logic signed [31:0] acc_value;
    logic [9:0]         read_index;
  } out_item_t;

  // Geometry the pixel scan works to; input sizes are already clamped.
  typedef struct packed {
    logic [5:0] out_w;
    logic [5:0] out_h;
    logic [5:0] in_w;
    logic [5:0] in_h;
    logic [3:0] stride;
  } geom_t;

  // Position the scan presents in the current cycle.
  typedef struct packed {
    logic [PIX_W-1:0] pix;
    logic [DIM_W-1:0] row;
    logic [DIM_W-1:0] col;
    logic             in_range;
    logic             last;
  } scan_t;

endpackage

`default_nettype wire

@@ hdl/sparse_conv_weight_scatter_accumulate_top.sv @@
// ----------------------------------------------------------------------------
// sparse_conv_weight_scatter_accumulate_top: sparse int8 convolution scatter
// Activation store, per-pixel 32-bit accumulators and the sequencer that
// scatters one nonzero weight tap over the whole output plane.
// ----------------------------------------------------------------------------
// Items are transferred when start is high and busy is low. A load writes one
// activation and a read returns a result, neither raising busy; the result
// appears on out_item, marked by out_strobe, for exactly the following cycle.
// The receiver cannot stall: a result not taken in that cycle is lost.
// An apply item visits every output pixel, up to 1024, with one accumulator
// read-modify-write per pixel, keeping busy high through the scan and the
// drain state after it (busy does not rise at all when either output size is
// zero). A clear item, and likewise the end of reset, runs a clearing pass
// over the 1024 accumulators, one per cycle, during which busy is high.
// Configuration writes are taken at any time but must only be made while the
// block is idle.
// ----------------------------------------------------------------------------
`default_nettype none

module sparse_conv_weight_scatter_accumulate_top
  import scwsa_pkg::*;
(
  input  wire logic              clk,
  input  wire logic              rst_n,
  // Item channel
  input  wire logic              start,
  output logic                   busy,
  input  wire in_item_t          in_item,
  // Result channel
  output logic                   out_strobe,
  output out_item_t              out_item,
  // Configuration port
  input  wire logic              psel,
  input  wire logic              penable,
  input  wire logic              pwrite,
  input  wire logic [REG_AW-1:0] paddr,
  input  wire logic [31:0]       pwdata,
  output logic [31:0]            prdata,
  output logic                   pready
);

  // --------------------------------------------------------------------------
  // Configuration registers
  // --------------------------------------------------------------------------
  logic signed [8:0] input_offset_r;
  logic [5:0]        input_width_r;
  logic [5:0]        input_height_r;
  logic [5:0]        output_width_r;
  logic [5:0]        output_height_r;
  logic [3:0]        conv_stride_r;
  logic [2:0]        conv_pad_r;
  logic [3:0]        conv_dilation_r;
  logic              cfg_write;
  reg_index_t        cfg_index;

  assign pready    = 1'b1;
  assign cfg_write = psel && penable && pwrite && pready;
  assign cfg_index = reg_index_t'(paddr[REG_AW-1:2]);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      input_offset_r  <= '0;
      input_width_r   <= 6'd1;
      input_height_r  <= 6'd1;
      output_width_r  <= 6'd1;
      output_height_r <= 6'd1;
      conv_stride_r   <= 4'd1;
      conv_pad_r      <= '0;
      conv_dilation_r <= 4'd1;
    end else if (cfg_write) begin
      unique case (cfg_index)
        REG_INPUT_OFFSET:  input_offset_r  <= pwdata[8:0];
        REG_INPUT_WIDTH:   input_width_r   <= pwdata[5:0];
        REG_INPUT_HEIGHT:  input_height_r  <= pwdata[5:0];
        REG_OUTPUT_WIDTH:  output_width_r  <= pwdata[5:0];
        REG_OUTPUT_HEIGHT: output_height_r <= pwdata[5:0];
        REG_CONV_STRIDE:   conv_stride_r   <= pwdata[3:0];
        REG_CONV_PAD:      conv_pad_r      <= pwdata[2:0];
        REG_CONV_DILATION: conv_dilation_r <= pwdata[3:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (cfg_index)
      REG_INPUT_OFFSET:  prdata = {23'd0, input_offset_r};
      REG_INPUT_WIDTH:   prdata = {26'd0, input_width_r};
      REG_INPUT_HEIGHT:  prdata = {26'd0, input_height_r};
      REG_OUTPUT_WIDTH:  prdata = {26'd0, output_width_r};
      REG_OUTPUT_HEIGHT: prdata = {26'd0, output_height_r};
      REG_CONV_STRIDE:   prdata = {28'd0, conv_stride_r};
      REG_CONV_PAD:      prdata = {29'd0, conv_pad_r};
      REG_CONV_DILATION: prdata = {28'd0, conv_dilation_r};
      default:           prdata = '0;
    endcase
  end

  // Input sizes beyond the store are treated as the store's size.
  geom_t geom;
  always_comb begin
    geom.out_w  = output_width_r;
    geom.out_h  = output_height_r;
    geom.in_w   = (input_width_r > 6'(MAX_IN_DIM)) ? 6'(MAX_IN_DIM) : input_width_r;
    geom.in_h   = (input_height_r > 6'(MAX_IN_DIM)) ? 6'(MAX_IN_DIM) : input_height_r;
    geom.stride = conv_stride_r;
  end

  // --------------------------------------------------------------------------
  // Item decode and tap capture
  // --------------------------------------------------------------------------
  logic    accept;
  opcode_t op;
  logic    empty_plane;

  assign accept      = start && !busy;
  assign op          = opcode_t'(in_item.opcode);
  assign empty_plane = (output_width_r == 6'd0) || (output_height_r == 6'd0);

  // Kernel offset of the tap on each axis, less the padding.
  logic [6:0]              tap_dy;
  logic [6:0]              tap_dx;
  logic signed [POS_W-1:0] base_y;
  logic signed [POS_W-1:0] base_x;

  assign tap_dy = 7'(conv_dilation_r * in_item.tap_row);
  assign tap_dx = 7'(conv_dilation_r * in_item.tap_col);
  assign base_y = $signed({{(POS_W-7){1'b0}}, tap_dy}) -
                  $signed({{(POS_W-3){1'b0}}, conv_pad_r});
  assign base_x = $signed({{(POS_W-7){1'b0}}, tap_dx}) -
                  $signed({{(POS_W-3){1'b0}}, conv_pad_r});

  logic [CH_W-1:0]   tap_ch_r;
  logic signed [7:0] tap_weight_r;

  always_ff @(posedge clk) begin
    if (accept && op == OP_APPLY) begin
      tap_ch_r     <= in_item.channel;
      tap_weight_r <= in_item.weight;
    end
  end

  // --------------------------------------------------------------------------
  // Sequencer
  // --------------------------------------------------------------------------
  state_t           state_r, state_nxt;
  logic [PIX_W-1:0] clr_cnt_r, clr_cnt_nxt;
  logic             scan_init;
  logic             scan_adv;
  logic             clr_we;
  scan_t            scan;

  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      ST_CLEAR: begin
        if (clr_cnt_r == PIX_W'(MAX_OUT_PIXELS - 1)) begin
          state_nxt = ST_IDLE;
        end
      end
      ST_IDLE: begin
        if (accept && op == OP_APPLY && !empty_plane) begin
          state_nxt = ST_APPLY;
        end else if (accept && op == OP_CLEAR) begin
          state_nxt = ST_CLEAR;
        end
      end
      ST_APPLY: begin
        if (scan.last) begin
          state_nxt = ST_DRAIN;
        end
      end
      ST_DRAIN: state_nxt = ST_IDLE;
      default:  state_nxt = ST_CLEAR;
    endcase
  end

  always_comb begin
    busy      = 1'b1;
    scan_init = 1'b0;
    scan_adv  = 1'b0;
    clr_we    = 1'b0;
    unique case (state_r)
      ST_CLEAR: clr_we = 1'b1;
      ST_IDLE: begin
        busy      = 1'b0;
        scan_init = accept && op == OP_APPLY;
      end
      ST_APPLY: scan_adv = 1'b1;
      ST_DRAIN: ;
      default: ;
    endcase
  end

  // The sweep counter wraps to zero at the end of every pass.
  assign clr_cnt_nxt = clr_we ? clr_cnt_r + PIX_W'(1) : clr_cnt_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r   <= ST_CLEAR;
      clr_cnt_r <= '0;
    end else begin
      state_r   <= state_nxt;
      clr_cnt_r <= clr_cnt_nxt;
    end
  end

  scwsa_scan u_scan (
    .clk     (clk),
    .init    (scan_init),
    .advance (scan_adv),
    .geom    (geom),
    .base_y  (base_y),
    .base_x  (base_x),
    .scan    (scan)
  );

  // --------------------------------------------------------------------------
  // Activation store, laid out channel fastest, then column, then row
  // --------------------------------------------------------------------------
  logic              act_we;
  logic [7:0]        act_rdata;

  assign act_we = accept && op == OP_LOAD;

  scwsa_ram #(
    .WIDTH (8),
    .DEPTH (STORE_DEPTH)
  ) u_act_ram (
    .clk   (clk),
    .we    (act_we),
    .waddr ({in_item.act_row, in_item.act_col, in_item.channel}),
    .wdata (in_item.activation),
    .re    (scan_adv),
    .raddr ({scan.row, scan.col, tap_ch_r}),
    .rdata (act_rdata)
  );

  // --------------------------------------------------------------------------
  // Accumulators: the scan issues a read per pixel, and in the next cycle the
  // stored sum and the activation come back and the new sum is written.
  // Pixels of one tap are all distinct, so no write can overtake a read.
  // --------------------------------------------------------------------------
  logic              s1_valid_r;
  logic [PIX_W-1:0]  s1_pix_r;
  logic              rd_pend_r;
  logic [PIX_W-1:0]  rd_index_r;
  logic              read_go;
  logic              acc_re;
  logic [PIX_W-1:0]  acc_raddr;
  logic [31:0]       acc_rdata;
  logic              acc_we;
  logic [PIX_W-1:0]  acc_waddr;
  logic [31:0]       acc_wdata;
  logic signed [9:0]  act_biased;
  logic signed [17:0] product;

  assign read_go   = accept && op == OP_READ;
  assign acc_re    = read_go || scan_adv;
  assign acc_raddr = scan_adv ? scan.pix : in_item.out_index;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
      rd_pend_r  <= 1'b0;
    end else begin
      s1_valid_r <= scan_adv && scan.in_range;
      rd_pend_r  <= read_go;
    end
  end

  always_ff @(posedge clk) begin
    s1_pix_r <= scan.pix;
    if (read_go) begin
      rd_index_r <= in_item.out_index;
    end
  end

  assign act_biased = $signed({act_rdata[7], act_rdata[7], act_rdata}) +
                      $signed({input_offset_r[8], input_offset_r});
  assign product    = act_biased * tap_weight_r;

  assign acc_we    = clr_we || s1_valid_r;
  assign acc_waddr = clr_we ? clr_cnt_r : s1_pix_r;
  assign acc_wdata = clr_we ? 32'd0 : acc_rdata + 32'(product);

  scwsa_ram #(
    .WIDTH (32),
    .DEPTH (MAX_OUT_PIXELS)
  ) u_acc_ram (
    .clk   (clk),
    .we    (acc_we),
    .waddr (acc_waddr),
    .wdata (acc_wdata),
    .re    (acc_re),
    .raddr (acc_raddr),
    .rdata (acc_rdata)
  );

  // Read results come straight from the registered memory output.
  assign out_strobe          = rd_pend_r;
  assign out_item.acc_value  = acc_rdata;
  assign out_item.read_index = rd_index_r;

  // --------------------------------------------------------------------------
  // Assertions
  // --------------------------------------------------------------------------
  // A result is only ever shown in the cycle after a read transfer.
  a_result_follows_read: assert property (@(posedge clk) disable iff (!rst_n)
    out_strobe |-> $past(start && !busy && in_item.opcode == OP_READ))
    else $error("result strobe without a preceding read transfer");

  // An accumulator update never lands outside the scan and its drain cycle.
  a_update_in_apply: assert property (@(posedge clk) disable iff (!rst_n)
    s1_valid_r |-> (state_r == ST_APPLY || state_r == ST_DRAIN))
    else $error("accumulator update outside an apply");

  // The clearing pass never shares the write port with a tap update.
  a_clear_exclusive: assert property (@(posedge clk) disable iff (!rst_n)
    clr_we |-> !s1_valid_r && !scan_adv)
    else $error("clearing pass overlaps a tap update");

endmodule

`default_nettype wire

@@ hdl/scwsa_ram.sv @@
// ----------------------------------------------------------------------------
// scwsa_ram: generic simple dual-port RAM
// One write port and one read port; read data is registered and holds while
// no read is enabled.
// ----------------------------------------------------------------------------
`default_nettype none

module scwsa_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 256
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] waddr,
  input  wire logic [WIDTH-1:0]         wdata,
  input  wire logic                     re,
  input  wire logic [$clog2(DEPTH)-1:0] raddr,
  output logic      [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

`default_nettype wire

@@ hdl/scwsa_scan.sv @@
// ----------------------------------------------------------------------------
// scwsa_scan: output pixel scan for one weight tap
// Walks the output plane in row-major order, keeping the matching input
// position by repeated addition of the stride.
// ----------------------------------------------------------------------------
`default_nettype none

module scwsa_scan
  import scwsa_pkg::*;
(
  input  wire logic                    clk,
  input  wire logic                    init,
  input  wire logic                    advance,
  input  wire geom_t                   geom,
  input  wire logic signed [POS_W-1:0] base_y,
  input  wire logic signed [POS_W-1:0] base_x,
  output scan_t                        scan
);

  logic [5:0]              oy_r, oy_nxt;
  logic [5:0]              ox_r, ox_nxt;
  logic signed [POS_W-1:0] iy_r, iy_nxt;
  logic signed [POS_W-1:0] ix_r, ix_nxt;
  logic signed [POS_W-1:0] base_x_r;
  logic [PIX_W-1:0]        pix_r, pix_nxt;
  logic                    row_end;
  logic                    y_ok;
  logic                    x_ok;
  logic signed [POS_W-1:0] step;

  assign step    = $signed({{(POS_W-4){1'b0}}, geom.stride});
  assign row_end = (ox_r == geom.out_w - 6'd1);

  // A position is inside when it is not negative and below the input size.
  assign y_ok = !iy_r[POS_W-1] && (iy_r[POS_W-2:0] < (POS_W-1)'(geom.in_h));
  assign x_ok = !ix_r[POS_W-1] && (ix_r[POS_W-2:0] < (POS_W-1)'(geom.in_w));

  always_comb begin
    scan.pix      = pix_r;
    scan.row      = iy_r[DIM_W-1:0];
    scan.col      = ix_r[DIM_W-1:0];
    scan.in_range = y_ok && x_ok;
    scan.last     = (row_end && (oy_r == geom.out_h - 6'd1)) ||
                    (pix_r == PIX_W'(MAX_OUT_PIXELS - 1));
  end

  always_comb begin
    oy_nxt  = oy_r;
    ox_nxt  = ox_r;
    iy_nxt  = iy_r;
    ix_nxt  = ix_r;
    pix_nxt = pix_r;
    if (init) begin
      oy_nxt  = '0;
      ox_nxt  = '0;
      iy_nxt  = base_y;
      ix_nxt  = base_x;
      pix_nxt = '0;
    end else if (advance) begin
      pix_nxt = pix_r + PIX_W'(1);
      if (row_end) begin
        ox_nxt = '0;
        ix_nxt = base_x_r;
        oy_nxt = oy_r + 6'd1;
        iy_nxt = iy_r + step;
      end else begin
        ox_nxt = ox_r + 6'd1;
        ix_nxt = ix_r + step;
      end
    end
  end

  always_ff @(posedge clk) begin
    oy_r  <= oy_nxt;
    ox_r  <= ox_nxt;
    iy_r  <= iy_nxt;
    ix_r  <= ix_nxt;
    pix_r <= pix_nxt;
    if (init) begin
      base_x_r <= base_x;
    end
  end

endmodule

`default_nettype wire
